### hw/rtl/nonprint_escape_line_folder_defines.svh
// Assertion macros shared by the escape and line folding RTL.
`ifndef NONPRINT_ESCAPE_LINE_FOLDER_DEFINES_SVH
`define NONPRINT_ESCAPE_LINE_FOLDER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NEPL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NEPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/nepl_pkg.sv
// Types, constants and character helpers for the escape and line folding block.
package nepl_pkg;

    localparam int COUNT_BITS_DEF = 12;
    localparam int LIMIT_W        = 12;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_INDEX_W    = 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int MAX_RESULTS    = 12;
    localparam int STEP_W         = $clog2(MAX_RESULTS);
    localparam int MARKER_LEN     = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd80;

    localparam logic [CFG_INDEX_W-1:0] REG_HEX_MODE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_LIMIT = 1'd1;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_C   = 8'h63;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_TAB,
        KIND_HEX,
        KIND_OCT
    } nepl_kind_t;

    typedef struct packed {
        nepl_kind_t kind;
        logic [7:0] data;
        logic       brk;
    } nepl_desc_t;

    function automatic logic [STEP_W-1:0] body_len(input nepl_kind_t kind);
        logic [STEP_W-1:0] len;
        case (kind)
            KIND_PLAIN: len = STEP_W'(1);
            KIND_TAB:   len = STEP_W'(2);
            KIND_HEX:   len = STEP_W'(4);
            KIND_OCT:   len = STEP_W'(5);
            default:    len = STEP_W'(1);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
            ch = CH_ZERO + {4'd0, nib};
        else
            ch = CH_LOWER_A + {4'd0, nib} - 8'd10;
        return ch;
    endfunction

    function automatic logic [7:0] body_char(input nepl_kind_t kind, input logic [7:0] data,
                                             input logic [2:0] pos);
        logic [7:0] ch;
        ch = CH_BACKSLASH;
        case (kind)
            KIND_PLAIN: ch = data;
            KIND_TAB:   ch = (pos == 3'd0) ? CH_BACKSLASH : CH_LOWER_C;
            KIND_HEX:
            begin
                case (pos)
                    3'd0:    ch = CH_BACKSLASH;
                    3'd1:    ch = CH_LOWER_X;
                    3'd2:    ch = hex_digit(data[7:4]);
                    default: ch = hex_digit(data[3:0]);
                endcase
            end
            KIND_OCT:
            begin
                case (pos)
                    3'd0:    ch = CH_BACKSLASH;
                    3'd1:    ch = CH_ZERO;
                    3'd2:    ch = CH_ZERO + {6'd0, data[7:6]};
                    3'd3:    ch = CH_ZERO + {5'd0, data[5:3]};
                    default: ch = CH_ZERO + {5'd0, data[2:0]};
                endcase
            end
            default: ch = data;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] marker_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_SPACE;
            3'd6:    ch = CH_NEWLINE;
            default: ch = CH_GT;
        endcase
        return ch;
    endfunction

endpackage

### hw/rtl/nepl_if.sv
// Valid/ready channel interfaces for input bytes and output characters.
interface nepl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface nepl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

### hw/rtl/nepl_front.sv
// Front end: configuration registers, byte classification and line counting.
module nepl_front #(
    parameter int COUNT_BITS = nepl_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [nepl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nepl_pkg::CFG_DATA_W-1:0]  cfg_data,
    nepl_in_if.sink                          in_chan,
    output logic                             push_valid,
    output nepl_pkg::nepl_desc_t             push_desc,
    input  logic                             push_ready
);
    import nepl_pkg::*;

    localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  hex_mode_reg;
    logic [LIMIT_W-1:0]    line_limit_reg;
    logic [COUNT_BITS-1:0] line_count_reg;
    logic [COUNT_BITS-1:0] line_count_next;
    logic [COUNT_BITS-1:0] count_base;
    logic [COUNT_BITS-1:0] count_inc;
    logic [LIMIT_W-1:0]    limit_eff;
    logic                  accept;
    nepl_kind_t            kind;
    logic                  brk;

    assign in_chan.ready = push_ready;
    assign accept        = in_chan.valid && push_ready;

    always_comb
    begin
        if (in_chan.in_byte == CH_NEWLINE)
            kind = KIND_PLAIN;
        else if (in_chan.in_byte == CH_TAB)
            kind = KIND_TAB;
        else if (in_chan.in_byte inside {[CH_SPACE:CH_TILDE]})
            kind = KIND_PLAIN;
        else if (hex_mode_reg)
            kind = KIND_HEX;
        else
            kind = KIND_OCT;
    end

    // A newline restarts the count before the increment; the count saturates.
    always_comb
    begin
        count_base = (in_chan.in_byte == CH_NEWLINE) ? '0 : line_count_reg;
        count_inc  = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
        limit_eff  = (line_limit_reg == '0) ? LIMIT_W'(1) : line_limit_reg;
        brk        = (CMP_W'(count_inc) >= CMP_W'(limit_eff));
        line_count_next = brk ? COUNT_BITS'(1) : count_inc;
    end

    assign push_valid     = in_chan.valid;
    assign push_desc.kind = kind;
    assign push_desc.data = in_chan.in_byte;
    assign push_desc.brk  = brk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_mode_reg   <= 1'b0;
            line_limit_reg <= LIMIT_RESET;
            line_count_reg <= COUNT_BITS'(1);
        end
        else
        begin
            if (cfg_we && cfg_index == REG_HEX_MODE)
                hex_mode_reg <= cfg_data[0];
            if (cfg_we && cfg_index == REG_LINE_LIMIT)
                line_limit_reg <= cfg_data[LIMIT_W-1:0];
            if (accept)
                line_count_reg <= line_count_next;
        end
    end

endmodule

### hw/rtl/nepl_queue.sv
// Short descriptor queue that decouples the front end from the emitter.
`include "nonprint_escape_line_folder_defines.svh"

module nepl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  nepl_pkg::nepl_desc_t push_desc,
    output logic                 push_ready,
    output logic                 pop_valid,
    output nepl_pkg::nepl_desc_t pop_desc,
    input  logic                 pop_ready
);
    import nepl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    nepl_desc_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

    `NEPL_ASSERT_SAME(a_queue_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `NEPL_ASSERT_SAME(a_queue_ptrs, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "pointers skewed")
    `NEPL_ASSERT_NEXT(a_queue_fill, push && !pop, count_reg != '0, "push lost")

endmodule

### hw/rtl/nepl_back.sv
// Back end: steps through the characters of each descriptor into the output register.
`include "nonprint_escape_line_folder_defines.svh"

module nepl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    input  nepl_pkg::nepl_desc_t pop_desc,
    output logic                 pop_ready,
    nepl_out_if.source           out_chan
);
    import nepl_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] len;
    logic [STEP_W-1:0] total;
    logic [STEP_W-1:0] mark_pos;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_char_reg;
    logic              run_last_reg;
    logic [7:0]        char_cur;
    logic              last_cur;
    logic              load;

    always_comb
    begin
        len      = body_len(pop_desc.kind);
        total    = pop_desc.brk ? len + STEP_W'(MARKER_LEN) : len;
        mark_pos = step_reg - len;
        if (step_reg < len)
            char_cur = body_char(pop_desc.kind, pop_desc.data, step_reg[2:0]);
        else
            char_cur = marker_char(mark_pos[2:0]);
        last_cur = (step_reg == total - 1'b1);
    end

    // The output register takes a new character whenever a descriptor is waiting and it is empty or being drained.
    assign load      = pop_valid && (!out_valid_reg || out_chan.ready);
    assign pop_ready = load && last_cur;

    always_comb
    begin
        step_next = step_reg;
        if (pop_ready)
            step_next = '0;
        else if (load)
            step_next = step_reg + 1'b1;

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_chan.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= char_cur;
            run_last_reg <= last_cur;
        end
    end

    assign out_chan.valid    = out_valid_reg;
    assign out_chan.out_char = out_char_reg;
    assign out_chan.run_last = run_last_reg;

    `NEPL_ASSERT_SAME(a_step_bound, pop_valid, step_reg < total, "step past end of run")
    `NEPL_ASSERT_SAME(a_step_idle, !pop_valid, step_reg == '0, "step moved without work")
    `NEPL_ASSERT_NEXT(a_step_restart, pop_ready, step_reg == '0 && out_valid_reg && run_last_reg,
                      "run end not marked")

endmodule

### hw/rtl/nonprint_escape_line_folder.sv
// Top level of the non-printable escaper with line folding.
// Each input byte is classified and line-counted by the front end in the cycle it is
// accepted, then queued; while the output is ready, the back end emits one output
// character per cycle into an output register: one for a printable byte or newline,
// two for a tab, four for a hex escape, five for an octal escape, plus seven when
// the break marker follows. An input byte therefore yields 1 to 12 output characters,
// and printable text flows at one byte per cycle; the output register sets that rate.
// A byte's first character passes through a queue slot and then the output register.
module nonprint_escape_line_folder #(
    parameter int COUNT_BITS = nepl_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [nepl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nepl_pkg::CFG_DATA_W-1:0]  cfg_data,
    nepl_in_if.sink                          in_chan,
    nepl_out_if.source                       out_chan
);
    import nepl_pkg::*;

    logic       push_valid;
    logic       push_ready;
    nepl_desc_t push_desc;
    logic       pop_valid;
    logic       pop_ready;
    nepl_desc_t pop_desc;

    nepl_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_chan    (in_chan),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .push_ready (push_ready)
    );

    nepl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_desc   (pop_desc),
        .pop_ready  (pop_ready)
    );

    nepl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_desc  (pop_desc),
        .pop_ready (pop_ready),
        .out_chan  (out_chan)
    );

endmodule
